FILE: src/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types, constants and status codes of the split-chunk pattern finder.
// ----------------------------------------------------------------------------
`default_nettype none
package scpf_pkg;

  localparam int unsigned TX_BYTES_DEF      = 4096;
  localparam int unsigned PATTERN_BYTES_DEF = 128;
  localparam int unsigned DESC_BYTES        = 43;
  localparam int unsigned DESC_BITS         = DESC_BYTES * 8;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam logic [7:0] MAGIC0 = 8'h92;
  localparam logic [7:0] MAGIC1 = 8'h7A;
  localparam logic [7:0] MAGIC2 = 8'h59;

  typedef enum logic [2:0] {
    ST_NOT_FOUND = 3'd0,
    ST_FOUND     = 3'd1,
    ST_DESC_END  = 3'd2,
    ST_SECT_END  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // one queued input transaction
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_COND, B_MRD, B_MCHK, B_DESC, B_CPRD, B_CPWR,
    B_CHA, B_CHB, B_CMPRD, B_CMPCK, B_CHEND
  } back_state_e;

endpackage
`default_nettype wire

FILE: src/scpf_front.sv
// ----------------------------------------------------------------------------
// scpf_front
// Accepts transactions and queues them for the search engine.
// ----------------------------------------------------------------------------
`default_nettype none
module scpf_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire                 mode_i,
  input  wire  [7:0]          data_byte_i,
  input  wire                 last_i,
  output logic                item_valid_o,
  output scpf_pkg::item_t     item_o,
  input  wire                 item_pop_i
);
  localparam int unsigned QD  = scpf_pkg::QUEUE_DEPTH;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  scpf_pkg::item_t mem_q [QD];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign busy         = (cnt_q == QCW'(QD));
  assign push         = start && !busy;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? QAW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? QAW'(rd_q + 1'b1) : rd_q;
    cnt_d = QCW'(cnt_q + QCW'(push) - QCW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{mode: mode_i, data_byte: data_byte_i, last: last_i};
    end
  end
endmodule
`default_nettype wire

FILE: src/scpf_back.sv
// ----------------------------------------------------------------------------
// scpf_back
// Byte stores and the search sequencer: magic scan, descriptor, chunk gather.
// ----------------------------------------------------------------------------
`default_nettype none
module scpf_back #(
  parameter int unsigned TX_BYTES      = scpf_pkg::TX_BYTES_DEF,
  parameter int unsigned PATTERN_BYTES = scpf_pkg::PATTERN_BYTES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  input  scpf_pkg::item_t     item_i,
  output logic                item_pop_o,
  output logic                res_valid_o,
  output logic [2:0]          status_o,
  output logic [3:0]          failed_chunk_o
);
  localparam int unsigned TAW  = $clog2(TX_BYTES);
  localparam int unsigned TCW  = $clog2(TX_BYTES + 1);
  localparam int unsigned PAW  = $clog2(PATTERN_BYTES);
  localparam int unsigned PCW  = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned CURW = ((TCW > 16) ? TCW : 16) + 1;
  localparam int unsigned TOTW = ((PCW > 11) ? PCW : 11) + 1;
  localparam int unsigned DB   = scpf_pkg::DESC_BITS;
  localparam int unsigned OFW  = $clog2(DB + 1);

  logic [7:0] tx_mem  [TX_BYTES];
  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] tx_rd_q, pat_rd_q;
  logic [TAW-1:0] tx_raddr;
  logic [PAW-1:0] pat_raddr;
  logic tx_we, pat_we;

  scpf_pkg::back_state_e st_q, st_d;
  logic [PCW-1:0]  pc_q, pc_d;
  logic [TCW-1:0]  tc_q, tc_d, scan_q, scan_d, mark_q, mark_d;
  logic            ovf_q, ovf_d;
  logic [1:0]      mstg_q, mstg_d;
  logic [2:0]      sw_q, sw_d;
  logic [4:0]      ow_q, ow_d;
  logic [3:0]      nch_q, nch_d, idx_q, idx_d;
  logic [5:0]      nb_q, nb_d, j_q, j_d;
  logic [DB-1:0]   desc_q;
  logic            desc_we;
  logic [OFW-1:0]  off_q, off_d;
  logic [CURW-1:0] cur_q, cur_d, soff_q, soff_d;
  logic [TOTW-1:0] tot_q, tot_d, len_q, len_d, k_q, k_d;
  logic            same_q, same_d, pok_q, pok_d;
  logic            rv_q, rv_d;
  logic [2:0]      rs_q, rs_d;
  logic [3:0]      rf_q, rf_d;

  logic [8:0]      bits;
  logic [DB-1:0]   sh_off, sh_len;
  logic [CURW-1:0] cur_new;
  logic [TOTW-1:0] pidx;

  assign bits    = 9'(nch_q) * 9'(ow_q) + 9'(sw_q) * 9'(4'(nch_q - 4'd1));
  assign sh_off  = desc_q >> off_q;
  assign sh_len  = desc_q >> OFW'(off_q - OFW'(sw_q));
  assign cur_new = cur_q + soff_q;
  assign pidx    = tot_q + k_q;

  // memory control
  always_comb begin
    item_pop_o = (st_q == scpf_pkg::B_IDLE) && item_valid_i;
    tx_we      = item_pop_o && item_i.mode && (tc_q < TCW'(TX_BYTES));
    pat_we     = item_pop_o && !item_i.mode && (pc_q < PCW'(PATTERN_BYTES));
    desc_we    = (st_q == scpf_pkg::B_CPWR);
    pat_raddr  = pidx[PAW-1:0];
    case (st_q)
      scpf_pkg::B_CPRD:  tx_raddr = TAW'(scan_q + TCW'(j_q));
      scpf_pkg::B_CMPRD: tx_raddr = TAW'(cur_q + CURW'(k_q));
      default:           tx_raddr = scan_q[TAW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tx_we)  tx_mem[tc_q[TAW-1:0]] <= item_i.data_byte;
    if (pat_we) pat_mem[pc_q[PAW-1:0]] <= item_i.data_byte;
    tx_rd_q  <= tx_mem[tx_raddr];
    pat_rd_q <= pat_mem[pat_raddr];
    if (desc_we) desc_q[8*(nb_q - 6'd1 - j_q) +: 8] <= tx_rd_q;
  end

  // next state and datapath
  always_comb begin
    logic fin;
    logic [2:0] fst;
    logic [3:0] ffc;
    fin = 1'b0; fst = scpf_pkg::ST_NOT_FOUND; ffc = '0;
    st_d = st_q; pc_d = pc_q; tc_d = tc_q; ovf_d = ovf_q; scan_d = scan_q;
    mark_d = mark_q; mstg_d = mstg_q; sw_d = sw_q; ow_d = ow_q; nch_d = nch_q;
    idx_d = idx_q; nb_d = nb_q; j_d = j_q; off_d = off_q; cur_d = cur_q;
    soff_d = soff_q; tot_d = tot_q; len_d = len_q; k_d = k_q; same_d = same_q;
    pok_d = pok_q; rv_d = 1'b0; rs_d = rs_q; rf_d = rf_q;
    unique case (st_q)
      scpf_pkg::B_IDLE: begin
        if (item_pop_o) begin
          if (!item_i.mode) begin
            if (pat_we) pc_d = PCW'(pc_q + 1'b1);
            else        ovf_d = 1'b1;
          end else begin
            if (tx_we) tc_d = TCW'(tc_q + 1'b1);
            else       ovf_d = 1'b1;
            if (item_i.last) begin
              scan_d = '0;
              mstg_d = '0;
              if (ovf_d) begin
                fin = 1'b1; fst = scpf_pkg::ST_OVERFLOW;
              end else begin
                st_d = scpf_pkg::B_COND;
              end
            end
          end
        end
      end
      scpf_pkg::B_COND: begin
        mstg_d = '0;
        if ((CURW'(scan_q) + CURW'(5)) < CURW'(tc_q)) st_d = scpf_pkg::B_MRD;
        else fin = 1'b1;
      end
      scpf_pkg::B_MRD: begin
        scan_d = TCW'(scan_q + 1'b1);
        st_d   = scpf_pkg::B_MCHK;
      end
      scpf_pkg::B_MCHK: begin
        case (mstg_q)
          2'd0: st_d = (tx_rd_q == scpf_pkg::MAGIC0) ? scpf_pkg::B_MRD : scpf_pkg::B_COND;
          2'd1: st_d = (tx_rd_q == scpf_pkg::MAGIC1) ? scpf_pkg::B_MRD : scpf_pkg::B_COND;
          2'd2: st_d = (tx_rd_q == scpf_pkg::MAGIC2) ? scpf_pkg::B_MRD : scpf_pkg::B_COND;
          default: begin
            mark_d = TCW'(scan_q - 1'b1);
            sw_d   = 3'd4 + {1'b0, tx_rd_q[1:0]};
            ow_d   = 5'd4 + {1'b0, tx_rd_q[3:2], 2'b00};
            nch_d  = tx_rd_q[7:4];
            st_d   = scpf_pkg::B_DESC;
          end
        endcase
        mstg_d = mstg_q + 2'd1;
      end
      scpf_pkg::B_DESC: begin
        nb_d = (nch_q == '0) ? 6'd0 : 6'(bits[8:3] + 6'd1);
        if (CURW'(nb_d) > CURW'(tc_q - scan_q)) begin
          fin = 1'b1; fst = scpf_pkg::ST_DESC_END;
        end else begin
          j_d    = '0;
          cur_d  = '0;
          tot_d  = '0;
          same_d = 1'b1;
          idx_d  = 4'(nch_q - 4'd1);
          off_d  = OFW'({nb_d, 3'b000} - 9'(ow_q));
          if (nch_q == '0)    st_d = scpf_pkg::B_CHEND;
          else                st_d = scpf_pkg::B_CPRD;
        end
      end
      scpf_pkg::B_CPRD: st_d = scpf_pkg::B_CPWR;
      scpf_pkg::B_CPWR: begin
        j_d  = 6'(j_q + 1'b1);
        st_d = (j_d == nb_q) ? scpf_pkg::B_CHA : scpf_pkg::B_CPRD;
      end
      scpf_pkg::B_CHA: begin
        soff_d = CURW'(sh_off[15:0] & 16'((17'h1 << ow_q) - 17'h1));
        if (idx_q == '0) begin
          if (tot_q > TOTW'(pc_q)) begin
            fin = 1'b1; fst = scpf_pkg::ST_SECT_END;
          end
          len_d = TOTW'(TOTW'(pc_q) - tot_q);
        end else begin
          len_d = TOTW'(sh_len[6:0] & 7'((8'h1 << sw_q) - 8'h1));
        end
        if (!fin) st_d = scpf_pkg::B_CHB;
      end
      scpf_pkg::B_CHB: begin
        if (cur_new > CURW'(tc_q) || CURW'(len_q) > CURW'(CURW'(tc_q) - cur_new)) begin
          fin = 1'b1; fst = scpf_pkg::ST_SECT_END; ffc = idx_q;
        end else begin
          cur_d = cur_new;
          k_d   = '0;
          st_d  = (len_q == '0 || !same_q) ? scpf_pkg::B_CHEND : scpf_pkg::B_CMPRD;
        end
      end
      scpf_pkg::B_CMPRD: begin
        pok_d = (pidx < TOTW'(pc_q));
        st_d  = scpf_pkg::B_CMPCK;
      end
      scpf_pkg::B_CMPCK: begin
        if (!pok_q || tx_rd_q != pat_rd_q) same_d = 1'b0;
        k_d  = TOTW'(k_q + 1'b1);
        st_d = (k_d == len_q || !same_d) ? scpf_pkg::B_CHEND : scpf_pkg::B_CMPRD;
      end
      scpf_pkg::B_CHEND: begin
        if (nch_q != '0) begin
          cur_d = cur_q + CURW'(len_q);
          tot_d = tot_q + len_q;
        end
        if (nch_q == '0 || idx_q == '0) begin
          if (same_q && tot_d == TOTW'(pc_q)) begin
            fin = 1'b1; fst = scpf_pkg::ST_FOUND;
          end else begin
            scan_d = mark_q;
            st_d   = scpf_pkg::B_COND;
          end
        end else begin
          idx_d = idx_q - 4'd1;
          off_d = OFW'(off_q - OFW'(ow_q) - OFW'(sw_q));
          st_d  = scpf_pkg::B_CHA;
        end
      end
      default: st_d = scpf_pkg::B_IDLE;
    endcase
    if (fin) begin
      rv_d = 1'b1; rs_d = fst; rf_d = ffc;
      pc_d = '0; tc_d = '0; ovf_d = 1'b0; scan_d = '0;
      st_d = scpf_pkg::B_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= scpf_pkg::B_IDLE;
      pc_q <= '0; tc_q <= '0; ovf_q <= 1'b0; scan_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d; tc_q <= tc_d; ovf_q <= ovf_d; scan_q <= scan_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_q <= mark_d; mstg_q <= mstg_d; sw_q <= sw_d; ow_q <= ow_d;
    nch_q <= nch_d; idx_q <= idx_d; nb_q <= nb_d; j_q <= j_d; off_q <= off_d;
    cur_q <= cur_d; soff_q <= soff_d; tot_q <= tot_d; len_q <= len_d;
    k_q <= k_d; same_q <= same_d; pok_q <= pok_d; rs_q <= rs_d; rf_q <= rf_d;
  end

  assign res_valid_o    = rv_q;
  assign status_o       = rs_q;
  assign failed_chunk_o = rf_q;
endmodule
`default_nettype wire

FILE: src/split_chunk_pattern_finder_core.sv
// ----------------------------------------------------------------------------
// split_chunk_pattern_finder_core
// Loads pattern and transaction bytes, then searches for split chunks.
// ----------------------------------------------------------------------------
// Usage:
//  - Drive start with mode_i/data_byte_i/last_i; a transaction is taken when
//    start is high and busy is low. mode 0 loads a pattern byte, mode 1 a
//    transaction byte; last_i on a transaction byte launches the search.
//  - Loading runs one byte per cycle while busy is low, through a 4-entry
//    queue in front of the search engine; busy rises only when it is full.
//  - The search walks the stored transaction through one read port of the
//    transaction store: each scanned byte is read and checked against the
//    magic, each descriptor byte is read and copied, each chunk byte is read
//    and compared, and each chunk has its fields taken and bounds checked.
//    Bytes queued meanwhile wait until the result is out. With nothing to
//    scan the result follows the bound check; an overflow answers from idle.
//  - One result per search: result_valid_o pulses for one cycle with
//    status_o and failed_chunk_o. The receiver cannot stall; the result is
//    taken in that cycle.
//  - Reset clears the queue, the byte counts and the overflow flag; store
//    contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none
module split_chunk_pattern_finder_core #(
  parameter int unsigned TX_BYTES      = scpf_pkg::TX_BYTES_DEF,
  parameter int unsigned PATTERN_BYTES = scpf_pkg::PATTERN_BYTES_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  wire        mode_i,
  input  wire  [7:0] data_byte_i,
  input  wire        last_i,
  output logic       result_valid_o,
  output logic [2:0] status_o,
  output logic [3:0] failed_chunk_o
);
  logic            item_valid, item_pop;
  scpf_pkg::item_t item;

  // front: accept and queue
  scpf_front u_front (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .data_byte_i, .last_i,
    .item_valid_o(item_valid), .item_o(item), .item_pop_i(item_pop)
  );

  // back: stores and search sequencer
  scpf_back #(.TX_BYTES(TX_BYTES), .PATTERN_BYTES(PATTERN_BYTES)) u_back (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_i(item),
    .item_pop_o(item_pop), .res_valid_o(result_valid_o),
    .status_o, .failed_chunk_o
  );
endmodule
`default_nettype wire

FILE: src/scpf_checker.sv
// ----------------------------------------------------------------------------
// scpf_checker
// Port-level checks of the pattern finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module scpf_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire       result_valid_o,
  input wire [2:0] status_o,
  input wire [3:0] failed_chunk_o
);
  // every result sends the engine back to idle, so results never come back to back
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o <= scpf_pkg::ST_OVERFLOW) else $error("bad status");

  a_failed_only_sect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != scpf_pkg::ST_SECT_END) |-> failed_chunk_o == 4'd0)
    else $error("failed chunk without section error");

  // no result in the first cycles after reset
  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(rst_ni, 2)) else $error("result too soon after reset");

  // the queue only fills up through an accepted transaction
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy)) else $error("busy without a transaction");
endmodule

bind split_chunk_pattern_finder_core scpf_checker u_scpf_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .status_o, .failed_chunk_o
);
`default_nettype wire

FILE: dv/tb_split_chunk_pattern_finder_core.sv
// ----------------------------------------------------------------------------
// tb_split_chunk_pattern_finder_core
// Self-checking bench: loads pattern and transaction bytes, predicts every
// search result with a behavioral model of the scan and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_split_chunk_pattern_finder_core;

  localparam int unsigned TXB = scpf_pkg::TX_BYTES_DEF;
  localparam int unsigned PTB = scpf_pkg::PATTERN_BYTES_DEF;

  // one input transaction plus an optional typed-in expectation
  typedef struct {
    bit                mode;
    bit [7:0]          data;
    bit                last;
    bit                has_exp;
    scpf_pkg::status_e exp_status;
    bit [3:0]          exp_chunk;
  } row_t;

  typedef struct {
    scpf_pkg::status_e status;
    bit [3:0]          chunk;
  } verdict_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       mode_i;
  logic [7:0] data_byte_i;
  logic       last_i;
  logic       result_valid_o;
  logic [2:0] status_o;
  logic [3:0] failed_chunk_o;

  split_chunk_pattern_finder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .failed_chunk_o (failed_chunk_o)
  );

  // model state of the finder
  bit [7:0]    pat_mem [PTB];
  bit [7:0]    tx_mem  [TXB];
  int unsigned pat_cnt;
  int unsigned tx_cnt;
  bit          ovf_flag;
  bit [7:0]    desc_mem [scpf_pkg::DESC_BYTES];

  verdict_t    verdict_q[$];
  int unsigned mismatches;
  bit          failed;
  int unsigned idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: descriptor bit k is bit k%8 of string byte (n-1-k/8)
  // ---------------------------------------------------------------------------
  function automatic int unsigned desc_field(int unsigned n, int unsigned from,
                                             int unsigned width);
    int unsigned v;
    int unsigned k;
    int unsigned b;
    v = 0;
    for (int unsigned j = 0; j < width && j < 31; j++) begin
      k = from + j;
      if (k < n * 8) begin
        b = n - 1 - (k >> 3);
        if (b < scpf_pkg::DESC_BYTES) v |= ((desc_mem[b] >> (k & 7)) & 1) << j;
      end
    end
    return v;
  endfunction

  function automatic scpf_pkg::status_e find_chunks(output bit [3:0] bad_chunk);
    int unsigned pos, mark, d, sw, ow, nchunks, n, waste, bits;
    int unsigned cur, total, e, soff, len, off;
    bit same;
    bad_chunk = '0;
    if (ovf_flag) return scpf_pkg::ST_OVERFLOW;
    pos = 0;
    while (pos + 5 < tx_cnt) begin
      if (tx_mem[pos++] != scpf_pkg::MAGIC0) continue;
      if (tx_mem[pos++] != scpf_pkg::MAGIC1) continue;
      if (tx_mem[pos++] != scpf_pkg::MAGIC2) continue;
      mark    = pos;
      d       = tx_mem[pos++];
      sw      = 4 + (d & 3);
      ow      = 4 + (d & 12);
      nchunks = d >> 4;
      if (nchunks == 0) begin
        // the bit count wraps: no descriptor bytes at all
        n     = 0;
        waste = 0;
      end else begin
        bits  = nchunks * ow + sw * (nchunks - 1);
        n     = bits / 8 + 1;
        waste = n * 8 - bits;
      end
      if (n > scpf_pkg::DESC_BYTES || n > tx_cnt - pos) return scpf_pkg::ST_DESC_END;
      for (int unsigned j = 0; j < n; j++) desc_mem[j] = tx_mem[pos + j];
      cur   = 0;
      total = 0;
      e     = 0;
      same  = 1'b1;
      for (int i = int'(nchunks) - 1; i >= 0; i--) begin
        off  = waste + i * (ow + sw);
        soff = desc_field(n, off, ow);
        if (i == 0) begin
          if (total > pat_cnt) return scpf_pkg::ST_SECT_END;
          len = pat_cnt - total;
        end else begin
          len = desc_field(n, off - sw, sw);
        end
        cur += soff;
        if (cur > tx_cnt || len > tx_cnt - cur) begin
          bad_chunk = i[3:0];
          return scpf_pkg::ST_SECT_END;
        end
        for (int unsigned k = 0; k < len; k++) begin
          if (e >= pat_cnt || tx_mem[cur + k] != pat_mem[e]) same = 1'b0;
          e++;
        end
        cur   += len;
        total += len;
      end
      if (same && e == pat_cnt) return scpf_pkg::ST_FOUND;
      pos = mark;
    end
    return scpf_pkg::ST_NOT_FOUND;
  endfunction

  function automatic void model_load(bit mode, bit [7:0] b, bit last);
    verdict_t v;
    if (!mode) begin
      if (pat_cnt < PTB) pat_mem[pat_cnt++] = b;
      else ovf_flag = 1'b1;
      return;
    end
    if (tx_cnt < TXB) tx_mem[tx_cnt++] = b;
    else ovf_flag = 1'b1;
    if (!last) return;
    v.status = find_chunks(v.chunk);
    verdict_q.insert(verdict_q.size(), v);
    pat_cnt  = 0;
    tx_cnt   = 0;
    ovf_flag = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change at falling edge, accept at rising edge with start && !busy
  // ---------------------------------------------------------------------------
  task automatic send_byte(bit mode, bit [7:0] b, bit last);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start       <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= b;
    last_i      <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model_load(mode, b, last);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // hold off until every pending search has reported
  task automatic drain();
    end_burst();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // well-formed candidate: chunks laid out from byte 0, then magic + descriptor
  task automatic send_candidate(bit corrupt);
    bit [7:0]    txb[$];
    bit [7:0]    patb[$];
    bit [343:0]  dbits;
    int unsigned nch, sw, ow, d, bits, n, waste, off, len, soff;
    nch = ($urandom_range(9) == 0) ? $urandom_range(15, 7) : $urandom_range(6, 1);
    d   = $urandom_range(15);
    sw  = 4 + (d & 3);
    ow  = 4 + (d & 12);
    d   = d | (nch << 4);
    bits  = nch * ow + sw * (nch - 1);
    n     = bits / 8 + 1;
    waste = n * 8 - bits;
    dbits = '0;
    for (int i = int'(nch) - 1; i >= 0; i--) begin
      off  = waste + i * (ow + sw);
      soff = $urandom_range(3);
      len  = $urandom_range(8);
      for (int unsigned j = 0; j < ow; j++) dbits[off + j] = soff[j];
      if (i != 0)
        for (int unsigned j = 0; j < sw; j++) dbits[off - sw + j] = len[j];
      repeat (soff) txb.insert(txb.size(), 8'($urandom));
      repeat (len) begin
        txb.insert(txb.size(), 8'($urandom));
        patb.insert(patb.size(), txb[$]);
      end
    end
    txb.insert(txb.size(), scpf_pkg::MAGIC0);
    txb.insert(txb.size(), scpf_pkg::MAGIC1);
    txb.insert(txb.size(), scpf_pkg::MAGIC2);
    txb.insert(txb.size(), 8'(d));
    for (int unsigned b = 0; b < n; b++)
      txb.insert(txb.size(), dbits[(n - 1 - b) * 8 +: 8]);
    repeat ($urandom_range(3)) txb.insert(txb.size(), 8'($urandom));
    if (corrupt) begin
      if ($urandom_range(1) && patb.size() != 0)
        patb[$urandom_range(patb.size() - 1)] ^= 8'(1 << $urandom_range(7));
      else
        txb[$urandom_range(txb.size() - 1)] ^= 8'(1 << $urandom_range(7));
    end
    // last on a pattern byte is ignored
    foreach (patb[i]) send_byte(1'b0, patb[i], 1'($urandom));
    foreach (txb[i]) send_byte(1'b1, txb[i], i == txb.size() - 1);
  endtask

  // loose bytes, biased toward the magic, sometimes overfilling the pattern
  task automatic send_noise();
    int unsigned plen, tlen;
    bit [7:0]    b;
    plen = ($urandom_range(29) == 0) ? $urandom_range(PTB + 3, PTB + 1)
                                     : $urandom_range(4);
    tlen = $urandom_range(24, 1);
    repeat (plen) send_byte(1'b0, 8'($urandom), 1'($urandom));
    for (int unsigned i = 0; i < tlen; i++) begin
      case ($urandom_range(5))
        0: b = scpf_pkg::MAGIC0;
        1: b = scpf_pkg::MAGIC1;
        2: b = scpf_pkg::MAGIC2;
        default: b = 8'($urandom);
      endcase
      send_byte(1'b1, b, i == tlen - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: strobe sampled at the rising edge, oldest expectation first
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (verdict_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d chunk=%0d",
                   $realtime, status_o, failed_chunk_o);
      end else begin
        if (status_o !== verdict_q[0].status || failed_chunk_o !== verdict_q[0].chunk) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch status exp=%0d got=%0d chunk exp=%0d got=%0d",
                     $realtime, verdict_q[0].status, status_o,
                     verdict_q[0].chunk, failed_chunk_o);
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  // directed rows; typed-in results where they are obvious
  row_t directed[] = '{
    // one byte, nothing to scan
    '{1'b1, 8'h00, 1'b1, 1'b1, scpf_pkg::ST_NOT_FOUND, 4'd0},
    // zero chunks with an empty pattern matches
    '{1'b1, scpf_pkg::MAGIC0, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, scpf_pkg::MAGIC1, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, scpf_pkg::MAGIC2, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'h00,  1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'hFF,  1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'hFF,  1'b1, 1'b1, scpf_pkg::ST_FOUND,     4'd0},
    // pattern byte with last set: ignored, stays a pattern byte
    '{1'b0, 8'hFF, 1'b1, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    // 15 chunks, descriptor string runs past the end
    '{1'b1, scpf_pkg::MAGIC0, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, scpf_pkg::MAGIC1, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, scpf_pkg::MAGIC2, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'hFF,  1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'h00,  1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'hAA,  1'b1, 1'b1, scpf_pkg::ST_DESC_END,  4'd0},
    // one chunk, offset 15 is past the stored bytes: chunk 0 fails
    '{1'b1, scpf_pkg::MAGIC0, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, scpf_pkg::MAGIC1, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, scpf_pkg::MAGIC2, 1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'h10,  1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'hF0,  1'b0, 1'b0, scpf_pkg::ST_NOT_FOUND, 4'd0},
    '{1'b1, 8'h55,  1'b1, 1'b1, scpf_pkg::ST_SECT_END,  4'd0}
  };

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = 1'b0;
    data_byte_i = 8'h00;
    last_i      = 1'b0;
    pat_cnt     = 0;
    tx_cnt      = 0;
    ovf_flag    = 1'b0;
    mismatches  = 0;
    failed      = 1'b0;
    idle_pct    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[r]) begin
      send_byte(directed[r].mode, directed[r].data, directed[r].last);
      if (directed[r].has_exp) begin
        verdict_q[$].status = directed[r].exp_status;
        verdict_q[$].chunk  = directed[r].exp_chunk;
      end
    end
    drain();

    // pattern store overfilled: the next search answers overflow at once
    for (int unsigned i = 0; i <= PTB; i++) send_byte(1'b0, 8'($urandom), 1'b0);
    send_byte(1'b1, 8'h00, 1'b1);
    verdict_q[$].status = scpf_pkg::ST_OVERFLOW;
    verdict_q[$].chunk  = 4'd0;
    drain();

    // four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 74;
        2: idle_pct = 0;
        default: idle_pct = 21;
      endcase
      for (int s = 0; s < 6; s++) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_candidate($urandom_range(4) == 0);
        if ($urandom_range(3) == 0) end_burst();
      end
      drain();
    end
    idle_pct = 0;
    send_candidate(1'b0);
    end_burst();

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (verdict_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
